### rtl/core/assert_macros.svh
// assertion helpers used by the back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/stlip_pkg.sv
package stlip_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int FRAC_BITS     = 24;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [31:0] wl;
        logic [31:0] n_val;
        logic [31:0] k_val;
    } t_item;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SCAN,
        BS_DIV,
        BS_MUL,
        BS_OUT
    } t_bstate;

endpackage

### rtl/core/sorted_table_linear_interpolator_unit.sv
// load, clear, unused op and query on an empty table give their result straight from idle;
//   an interpolating query scans the table, then runs the divider and the multiplier;
//   a query at or below the first point or past the last gives that point's values
// throughput: non-query items one per cycle unless the output stalls; a query holds the back end
// a 4-deep input queue keeps accepting while the back end works
// reset: synchronous active low, empties the table, the input queue and the output register
module sorted_table_linear_interpolator_unit #(
    parameter int DEPTH = stlip_pkg::DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // wavelength [31:0], n_value [63:32], k_value [95:64]
    input  logic [1:0]   i_s_tuser,   // op
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,   // n_out [31:0], k_out [63:32]
    output logic [1:0]   o_m_tuser    // status
);

    logic             f_valid, b_pop;
    stlip_pkg::t_item f_item;
    logic [31:0]      res_n, res_k;

    // front end: takes transactions and decodes the op into the queue
    stlip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_wl    (i_s_tdata[31:0]),
        .i_n     (i_s_tdata[63:32]),
        .i_k     (i_s_tdata[95:64]),
        .o_valid (f_valid),
        .o_item  (f_item),
        .i_pop   (b_pop)
    );

    // back end: table memory, scan, divider, multiplier and output register
    stlip_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .i_item   (f_item),
        .o_pop    (b_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_n      (res_n),
        .o_k      (res_k),
        .o_status (o_m_tuser)
    );

    assign o_m_tdata = {res_k, res_n};

endmodule

### rtl/core/stlip_front.sv
module stlip_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [31:0]          i_wl,
    input  logic [31:0]          i_n,
    input  logic [31:0]          i_k,
    output logic                 o_valid,
    output stlip_pkg::t_item     o_item,
    input  logic                 i_pop
);

    stlip_pkg::t_item                 r_buf [stlip_pkg::QUEUE_DEPTH];
    logic [stlip_pkg::QUEUE_AW-1:0]   r_wp, r_rp;
    logic [stlip_pkg::QUEUE_AW:0]     r_cnt;
    logic                             push, pop;
    stlip_pkg::t_item                 item_in;

    // classify the op code
    always_comb begin
        item_in.wl    = i_wl;
        item_in.n_val = i_n;
        item_in.k_val = i_k;
        case (i_op)
            stlip_pkg::OP_LOAD:  item_in.op = stlip_pkg::OP_LOAD;
            stlip_pkg::OP_QUERY: item_in.op = stlip_pkg::OP_QUERY;
            stlip_pkg::OP_CLEAR: item_in.op = stlip_pkg::OP_CLEAR;
            default:             item_in.op = stlip_pkg::OP_NONE;
        endcase
    end

    assign o_ready = (r_cnt != (stlip_pkg::QUEUE_AW+1)'(stlip_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### rtl/core/stlip_back.sv
`include "assert_macros.svh"

module stlip_back #(
    parameter int DEPTH = stlip_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  stlip_pkg::t_item   i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_n,
    output logic [31:0]        o_k,
    output logic [1:0]         o_status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int FB = stlip_pkg::FRAC_BITS;

    logic [95:0]   mem [DEPTH];
    logic [95:0]   r_rdata;
    logic [IW-1:0] rd_addr;
    logic          we;

    stlip_pkg::t_bstate r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_w, n_w;
    logic [95:0]   r_prev, n_prev;
    logic [95:0]   r_cur, n_cur;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_den, n_den;
    logic [FB:0]   r_q, n_q;
    logic [4:0]    r_cnt, n_cnt;
    logic [57:0]   r_acc, n_acc;
    logic [31:0]   r_rn, n_rn, r_rk, n_rk;
    logic [1:0]    r_rst, n_rst;
    logic          r_ov, n_ov;
    logic [31:0]   r_on, n_on, r_ok, n_ok;
    logic [1:0]    r_ost, n_ost;

    logic          slot_free;
    logic [31:0]   e_wl, num, den;
    logic [32:0]   dn, dk, mag_n, mag_k, mag, sh;
    logic [16:0]   mop;
    logic [41:0]   prod;
    logic [58:0]   acc_up;
    logic [33:0]   step_f, step_c;
    logic          neg;
    logic [31:0]   base, lerp;

    assign e_wl = r_rdata[31:0];
    assign num  = r_w - r_prev[31:0];
    assign den  = e_wl - r_prev[31:0];
    assign sh   = {r_rem, 1'b0};

    // signed differences of both channels
    assign dn    = {r_cur[63], r_cur[63:32]} - {r_prev[63], r_prev[63:32]};
    assign dk    = {r_cur[95], r_cur[95:64]} - {r_prev[95], r_prev[95:64]};
    assign mag_n = dn[32] ? (33'd0 - dn) : dn;
    assign mag_k = dk[32] ? (33'd0 - dk) : dk;
    assign mag   = (r_cnt >= 5'd2) ? mag_k : mag_n;
    assign mop   = r_cnt[0] ? mag[32:16] : {1'b0, mag[15:0]};
    assign prod  = r_q * mop;
    assign acc_up = {1'b0, r_acc} + {1'b0, prod, 16'd0};

    // floor and ceiling of the scaled step, and the finishing add
    assign neg    = (r_cnt == 5'd2) ? dn[32] : dk[32];
    assign base   = (r_cnt == 5'd2) ? r_prev[63:32] : r_prev[95:64];
    assign step_f = r_acc[57:FB];
    assign step_c = 34'(({1'b0, r_acc} + 59'(24'hFFFFFF)) >> FB);
    assign lerp   = neg ? (base - step_c[31:0]) : (base + step_f[31:0]);

    assign slot_free = !r_ov || i_ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_w     = r_w;
        n_prev  = r_prev;
        n_cur   = r_cur;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_rn    = r_rn;
        n_rk    = r_rk;
        n_rst   = r_rst;
        n_ov    = r_ov && !i_ready;
        n_on    = r_on;
        n_ok    = r_ok;
        n_ost   = r_ost;
        o_pop   = 1'b0;
        we      = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            stlip_pkg::BS_IDLE: begin
                if (i_valid && slot_free) begin
                    o_pop = 1'b1;
                    n_on  = '0;
                    n_ok  = '0;
                    n_ost = stlip_pkg::ST_OK;
                    n_ov  = 1'b1;
                    case (i_item.op)
                        stlip_pkg::OP_LOAD: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_ost = stlip_pkg::ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        stlip_pkg::OP_CLEAR: n_count = '0;
                        stlip_pkg::OP_QUERY: begin
                            if (r_count == '0) begin
                                n_ost = stlip_pkg::ST_EMPTY;
                            end else begin
                                n_ov    = 1'b0;
                                n_idx   = '0;
                                rd_addr = '0;
                                n_w     = i_item.wl;
                                n_state = stlip_pkg::BS_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            stlip_pkg::BS_SCAN: begin
                if (e_wl >= r_w) begin
                    if (r_idx == '0) begin
                        n_rn    = r_rdata[63:32];
                        n_rk    = r_rdata[95:64];
                        n_rst   = stlip_pkg::ST_OK;
                        n_state = stlip_pkg::BS_OUT;
                    end else begin
                        n_cur = r_rdata;
                        n_den = den;
                        n_cnt = '0;
                        if (num == den) begin
                            n_q   = (FB+1)'(1);
                            n_rem = '0;
                        end else begin
                            n_q   = '0;
                            n_rem = num;
                        end
                        n_state = stlip_pkg::BS_DIV;
                    end
                end else if (CW'(r_idx) == r_count - 1'b1) begin
                    n_rn    = r_rdata[63:32];
                    n_rk    = r_rdata[95:64];
                    n_rst   = stlip_pkg::ST_OK;
                    n_state = stlip_pkg::BS_OUT;
                end else begin
                    n_prev  = r_rdata;
                    n_idx   = r_idx + 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            stlip_pkg::BS_DIV: begin
                // one restoring quotient bit per cycle
                if (sh >= {1'b0, r_den}) begin
                    n_rem = 32'(sh - {1'b0, r_den});
                    n_q   = {r_q[FB-1:0], 1'b1};
                end else begin
                    n_rem = sh[31:0];
                    n_q   = {r_q[FB-1:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(FB - 1)) begin
                    n_cnt   = '0;
                    n_state = stlip_pkg::BS_MUL;
                end
            end
            stlip_pkg::BS_MUL: begin
                // low and high halves of each channel, then the finishing add
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[0]) n_acc = acc_up[57:0];
                else          n_acc = {16'd0, prod};
                if (r_cnt == 5'd2) n_rn = lerp;
                if (r_cnt == 5'd4) begin
                    n_rk    = lerp;
                    n_rst   = stlip_pkg::ST_OK;
                    n_state = stlip_pkg::BS_OUT;
                end
            end
            stlip_pkg::BS_OUT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_on    = r_rn;
                    n_ok    = r_rk;
                    n_ost   = r_rst;
                    n_state = stlip_pkg::BS_IDLE;
                end
            end
            default: n_state = stlip_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_count[IW-1:0]] <= {i_item.k_val, i_item.n_val, i_item.wl};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stlip_pkg::BS_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_w    <= n_w;
        r_prev <= n_prev;
        r_cur  <= n_cur;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_rn   <= n_rn;
        r_rk   <= n_rk;
        r_rst  <= n_rst;
        r_on   <= n_on;
        r_ok   <= n_ok;
        r_ost  <= n_ost;
    end

    assign o_valid  = r_ov;
    assign o_n      = r_on;
    assign o_k      = r_ok;
    assign o_status = r_ost;

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "point count overflow")
    `ASSERT_ALWAYS(a_rem_below_den, i_clk, i_rst_n, (r_state != stlip_pkg::BS_DIV) || (r_rem < r_den), "divider remainder out of range")
    `ASSERT_ALWAYS(a_t_bound, i_clk, i_rst_n, (r_state != stlip_pkg::BS_MUL) || (r_q <= (FB+1)'(1) << FB), "fraction above one")
    `ASSERT_NEXT(a_pop_idle, i_clk, i_rst_n, o_pop && (r_state == stlip_pkg::BS_IDLE) && (i_item.op != stlip_pkg::OP_QUERY), r_ov && (r_state == stlip_pkg::BS_IDLE), "non-query item gave no result")

endmodule

### tb/sorted_table_linear_interpolator_unit_test.sv
module sorted_table_linear_interpolator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = stlip_pkg::DEPTH_DEFAULT;

    // one lookup transaction as seen on the input stream
    typedef struct {
        stlip_pkg::t_op op;
        logic [31:0]    wl;
        logic [31:0]    nv;
        logic [31:0]    kv;
    } t_lookup;

    // one answer as seen on the result stream
    typedef struct {
        logic [31:0]        n;
        logic [31:0]        k;
        stlip_pkg::t_status st;
    } t_answer;

    // directed table row: typed answer used only when check_fixed is set
    typedef struct {
        t_lookup item;
        bit      check_fixed;
        t_answer fixed;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;   // wavelength [31:0], n_value [63:32], k_value [95:64]
    logic [1:0]  i_s_tuser;   // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;   // n_out [31:0], k_out [63:32]
    logic [1:0]  o_m_tuser;   // status

    sorted_table_linear_interpolator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // predictor's own copy of the table
    logic [31:0] tbl_wl [TBL_DEPTH];
    logic [31:0] tbl_n  [TBL_DEPTH];
    logic [31:0] tbl_k  [TBL_DEPTH];
    int          tbl_count;

    // answers still owed by the block, oldest first
    t_answer     pending_answers[$];
    bit          fixed_flags[$];
    t_answer     fixed_answers[$];
    int          error_count;
    bit          stim_done;
    bit          hold_off;     // long receiver stall request

    // clock: 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // a + floor(t * (b - a) / 2^24) with signed 32-bit endpoints
    function automatic logic [31:0] blend_q24(logic [31:0] a, logic [31:0] b,
                                              logic [63:0] t);
        longint   sa;
        longint   sb;
        longint   diff;
        longint   step;
        logic [63:0] mag;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        diff = sb - sa;
        if (diff >= 0) begin
            mag = 64'(diff) * t;
            step = longint'(mag >> 24);
        end else begin
            mag = 64'(-diff) * t;
            step = -longint'((mag + 64'hFF_FFFF) >> 24);
        end
        return 32'(sa + step);
    endfunction

    // applies one transaction to the predicted table and returns its answer
    function automatic t_answer lookup_answer(t_lookup it);
        t_answer     ans;
        int          idx;
        int          prv;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        ans = '{n: '0, k: '0, st: stlip_pkg::ST_OK};
        case (it.op)
            stlip_pkg::OP_LOAD: begin
                if (tbl_count >= TBL_DEPTH) begin
                    ans.st = stlip_pkg::ST_FULL;
                end else begin
                    tbl_wl[tbl_count] = it.wl;
                    tbl_n[tbl_count]  = it.nv;
                    tbl_k[tbl_count]  = it.kv;
                    tbl_count++;
                end
            end
            stlip_pkg::OP_CLEAR: begin
                tbl_count = 0;
            end
            stlip_pkg::OP_QUERY: begin
                if (tbl_count == 0) begin
                    ans.st = stlip_pkg::ST_EMPTY;
                end else begin
                    idx = 0;
                    while (idx < tbl_count && tbl_wl[idx] < it.wl) idx++;
                    if (idx == 0) begin
                        ans.n = tbl_n[0];
                        ans.k = tbl_k[0];
                    end else if (idx >= tbl_count) begin
                        ans.n = tbl_n[tbl_count-1];
                        ans.k = tbl_k[tbl_count-1];
                    end else begin
                        prv = idx - 1;
                        num = 64'(32'(it.wl - tbl_wl[prv]));
                        den = 64'(32'(tbl_wl[idx] - tbl_wl[prv]));
                        t = (den != 0) ? (num << 24) / den : 64'd0;
                        ans.n = blend_q24(tbl_n[prv], tbl_n[idx], t);
                        ans.k = blend_q24(tbl_k[prv], tbl_k[idx], t);
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // drives one transaction after a random gap and waits for acceptance
    task automatic send_lookup(t_lookup it, bit check_fixed, t_answer fixed);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {it.kv, it.nv, it.wl};
        i_s_tuser  <= it.op;
        do @(posedge i_clk); while (!o_s_tready);
        // accepted at this edge: predict in acceptance order
        pending_answers.insert(pending_answers.size(), lookup_answer(it));
        fixed_flags.insert(fixed_flags.size(), check_fixed);
        fixed_answers.insert(fixed_answers.size(), fixed);
    endtask

    function automatic t_lookup make_item(stlip_pkg::t_op op, logic [31:0] wl,
                                          logic [31:0] nv, logic [31:0] kv);
        t_lookup it;
        it.op = op;
        it.wl = wl;
        it.nv = nv;
        it.kv = kv;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stalls, one long hold-off, field-by-field compare
    initial begin
        t_answer exp_ans;
        t_answer got;
        bit      use_fixed;
        t_answer fixed;
        int      stall;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                // long stall so the input queue fills and backs up
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.n  = o_m_tdata[31:0];
            got.k  = o_m_tdata[63:32];
            got.st = stlip_pkg::t_status'(o_m_tuser);
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result n=%h k=%h status=%0d",
                         $time, got.n, got.k, got.st);
                error_count++;
            end else begin
                exp_ans   = pending_answers.pop_front();
                use_fixed = fixed_flags.pop_front();
                fixed     = fixed_answers.pop_front();
                if (use_fixed) exp_ans = fixed;
                if (got.n !== exp_ans.n) begin
                    $display("%0t: n_out expected %h actual %h", $time, exp_ans.n, got.n);
                    error_count++;
                end
                if (got.k !== exp_ans.k) begin
                    $display("%0t: k_out expected %h actual %h", $time, exp_ans.k, got.k);
                    error_count++;
                end
                if (got.st !== exp_ans.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_ans.st, got.st);
                    error_count++;
                end
            end
        end
    end

    // stimulus: directed table, then random phases
    initial begin
        t_row    rows[$];
        t_row    r;
        t_answer ok0;
        t_answer nofix;
        t_lookup it;
        int      sent;
        int      npts;
        logic [31:0] base_wl;
        ok0   = '{n: '0, k: '0, st: stlip_pkg::ST_OK};
        nofix = ok0;
        tbl_count   = 0;
        error_count = 0;
        stim_done   = 1'b0;
        hold_off    = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= stlip_pkg::OP_LOAD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // query on an empty table, unused op, then a small table and its corners
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0001_0000, '0, '0), 1,
                    '{n: '0, k: '0, st: stlip_pkg::ST_EMPTY}});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_NONE, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_LOAD, 32'h0000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0000_0000, '0, '0), 1,
                    '{n: 32'h8000_0000, k: 32'h7FFF_FFFF, st: stlip_pkg::ST_OK}});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_LOAD, 32'h0010_0000,
                    32'h7FFF_FFFF, 32'h8000_0000), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_LOAD, 32'h0020_0000,
                    32'h0100_0000, 32'hFF00_0000), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_LOAD, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h0000_0001), 1, ok0});
        // exact hit on a stored wavelength
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0010_0000, '0, '0), 1,
                    '{n: 32'h7FFF_FFFF, k: 32'h8000_0000, st: stlip_pkg::ST_OK}});
        // full-swing interpolation in both directions
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0008_0000, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0000_0001, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h000F_FFFF, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0018_0000, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'hFFFF_FFFE, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'hFFFF_FFFF, '0, '0), 1,
                    '{n: 32'hFFFF_FFFF, k: 32'h0000_0001, st: stlip_pkg::ST_OK}});
        // unsorted load: stored in arrival order
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_LOAD, 32'h0005_0000,
                    32'h1234_5678, 32'h8765_4321), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0003_0000, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h8000_0000, '0, '0),
                    0, nofix});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_CLEAR, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, ok0});
        rows.insert(rows.size(), '{make_item(stlip_pkg::OP_QUERY, 32'h0010_0000, '0, '0), 1,
                    '{n: '0, k: '0, st: stlip_pkg::ST_EMPTY}});
        foreach (rows[i]) begin
            r = rows[i];
            send_lookup(r.item, r.check_fixed, r.fixed);
        end

        // fill the table to depth, then a load into a full table and queries over it
        for (int i = 0; i < TBL_DEPTH; i++) begin
            send_lookup(make_item(stlip_pkg::OP_LOAD, 32'(i) << 20, $urandom, $urandom),
                        0, nofix);
        end
        send_lookup(make_item(stlip_pkg::OP_LOAD, 32'h1234_0000, 32'h1, 32'h1), 1,
                    '{n: '0, k: '0, st: stlip_pkg::ST_FULL});
        hold_off = 1'b1;   // receiver backs up while queries keep coming
        for (int i = 0; i < 10; i++) begin
            send_lookup(make_item(stlip_pkg::OP_QUERY, rand_word(), '0, '0), 0, nofix);
        end
        send_lookup(make_item(stlip_pkg::OP_QUERY, 32'hFFFF_FFFF, '0, '0), 0, nofix);

        // random phases: clear, load a short sorted table, query mostly inside it
        sent = 0;
        while (sent < 310) begin
            send_lookup(make_item(stlip_pkg::OP_CLEAR, $urandom, $urandom, $urandom),
                        0, nofix);
            sent++;
            npts = $urandom_range(1, 8);
            base_wl = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h00FF_FFFF);
            for (int j = 0; j < npts; j++) begin
                // occasionally unsorted or duplicate wavelengths
                if ($urandom_range(0, 9) != 0)
                    base_wl = base_wl + $urandom_range(1, 32'h0100_0000);
                it = make_item(stlip_pkg::OP_LOAD,
                               ($urandom_range(0, 9) == 0) ? rand_word() : base_wl,
                               rand_word(), rand_word());
                send_lookup(it, 0, nofix);
                sent++;
            end
            for (int j = 0; j < $urandom_range(2, 10); j++) begin
                case ($urandom_range(0, 9))
                    0: it = make_item(stlip_pkg::OP_NONE, $urandom, $urandom, $urandom);
                    1: it = make_item(stlip_pkg::OP_QUERY, rand_word(), $urandom, $urandom);
                    default: it = make_item(stlip_pkg::OP_QUERY,
                                            $urandom_range(0, 32'(base_wl) + 32'h0100_0000),
                                            $urandom, $urandom);
                endcase
                send_lookup(it, 0, nofix);
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run: drain, let the pipeline settle, report
    initial begin
        wait (stim_done);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
